// File: rtl/spq_pkg.sv
package spq_pkg;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
    localparam logic [1:0] FUNC_REMOVE  = 2'd2;

    localparam logic [1:0] ORDER_ASC  = 2'd0;
    localparam logic [1:0] ORDER_DESC = 2'd1;
    localparam logic [1:0] ORDER_FIFO = 2'd2;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_MISS = 2'd2;

    typedef struct packed {
        logic       ins;
        logic       deq;
        logic       rem;
        logic [1:0] order;
    } spq_ctl_t;

endpackage

// File: rtl/sorted_insert_priority_queue.sv
// The output register takes the result of a transaction at the clock edge that accepts it.
// Throughput: one transaction per cycle while the output is not stalled; every operation is settled in a single pass
// through the row of DEPTH cells, which compare and shift all entries at once.
// A transaction is taken while the output register is empty or being drained.
// Reset clears all cell valid bits, the occupancy count and the output valid flag,
// and sets the order to first-in first-out.
module sorted_insert_priority_queue #(
    parameter int DEPTH         = 16,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 16,
    parameter int CNT_WIDTH     = $clog2(DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               queue_order,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               func,
    input  logic [KEY_WIDTH-1:0]     item_key,
    input  logic [PAYLOAD_WIDTH-1:0] item_payload,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [KEY_WIDTH-1:0]     out_key,
    output logic [PAYLOAD_WIDTH-1:0] out_payload,
    output logic [CNT_WIDTH-1:0]     occupancy
);
    import spq_pkg::*;

    logic [1:0]               order_reg;
    logic [CNT_WIDTH-1:0]     count_reg;
    logic [CNT_WIDTH-1:0]     count_next;
    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [KEY_WIDTH-1:0]     out_key_reg;
    logic [KEY_WIDTH-1:0]     out_key_next;
    logic [PAYLOAD_WIDTH-1:0] out_payload_reg;
    logic [PAYLOAD_WIDTH-1:0] out_payload_next;

    logic                     accept;
    logic                     full;
    spq_ctl_t                 ctl;

    logic                     cell_valid [DEPTH];
    logic [KEY_WIDTH-1:0]     cell_key [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];
    logic                     found [DEPTH+1];
    logic [KEY_WIDTH-1:0]     take_key [DEPTH+1];
    logic [PAYLOAD_WIDTH-1:0] take_payload [DEPTH+1];

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign full      = count_reg == CNT_WIDTH'(DEPTH);

    always_comb
    begin
        ctl.ins   = accept && func == FUNC_INSERT && !full;
        ctl.deq   = accept && func == FUNC_DEQUEUE;
        ctl.rem   = accept && func == FUNC_REMOVE;
        ctl.order = order_reg;
    end

    assign found[0]        = 1'b0;
    assign take_key[0]     = '0;
    assign take_payload[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                     lv;
        logic [KEY_WIDTH-1:0]     lk;
        logic [PAYLOAD_WIDTH-1:0] lp;
        logic                     rv;
        logic [KEY_WIDTH-1:0]     rk;
        logic [PAYLOAD_WIDTH-1:0] rp;

        if (i == 0)
        begin : g_head
            assign lv = 1'b0;
            assign lk = '0;
            assign lp = '0;
        end
        else
        begin : g_mid
            assign lv = cell_valid[i-1];
            assign lk = cell_key[i-1];
            assign lp = cell_payload[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign rv = 1'b0;
            assign rk = '0;
            assign rp = '0;
        end
        else
        begin : g_body
            assign rv = cell_valid[i+1];
            assign rk = cell_key[i+1];
            assign rp = cell_payload[i+1];
        end

        spq_cell #(
            .KEY_WIDTH    (KEY_WIDTH),
            .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctl             (ctl),
            .new_key         (item_key),
            .new_payload     (item_payload),
            .left_valid      (lv),
            .left_key        (lk),
            .left_payload    (lp),
            .right_valid     (rv),
            .right_key       (rk),
            .right_payload   (rp),
            .found_in        (found[i]),
            .take_key_in     (take_key[i]),
            .take_payload_in (take_payload[i]),
            .valid           (cell_valid[i]),
            .key             (cell_key[i]),
            .payload         (cell_payload[i]),
            .found_out       (found[i+1]),
            .take_key_out    (take_key[i+1]),
            .take_payload_out(take_payload[i+1])
        );
    end

    always_comb
    begin
        count_next       = count_reg;
        status_next      = STATUS_DONE;
        out_key_next     = '0;
        out_payload_next = '0;
        priority if (ctl.ins)
        begin
            count_next = count_reg + CNT_WIDTH'(1);
        end
        else if (accept && func == FUNC_INSERT)
        begin
            status_next = STATUS_FULL;
        end
        else if (ctl.deq || ctl.rem)
        begin
            if (found[DEPTH])
            begin
                count_next       = count_reg - CNT_WIDTH'(1);
                out_key_next     = take_key[DEPTH];
                out_payload_next = take_payload[DEPTH];
            end
            else
            begin
                status_next = STATUS_MISS;
            end
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= ORDER_FIFO;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                order_reg <= queue_order;
            end
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            out_key_reg     <= out_key_next;
            out_payload_reg <= out_payload_next;
        end
    end

    logic [CNT_WIDTH-1:0] occupancy_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            occupancy_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_payload_reg;
    assign occupancy   = occupancy_reg;

endmodule

// File: rtl/spq_cell.sv
module spq_cell #(
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  spq_pkg::spq_ctl_t        ctl,
    input  logic [KEY_WIDTH-1:0]     new_key,
    input  logic [PAYLOAD_WIDTH-1:0] new_payload,
    input  logic                     left_valid,
    input  logic [KEY_WIDTH-1:0]     left_key,
    input  logic [PAYLOAD_WIDTH-1:0] left_payload,
    input  logic                     right_valid,
    input  logic [KEY_WIDTH-1:0]     right_key,
    input  logic [PAYLOAD_WIDTH-1:0] right_payload,
    input  logic                     found_in,
    input  logic [KEY_WIDTH-1:0]     take_key_in,
    input  logic [PAYLOAD_WIDTH-1:0] take_payload_in,
    output logic                     valid,
    output logic [KEY_WIDTH-1:0]     key,
    output logic [PAYLOAD_WIDTH-1:0] payload,
    output logic                     found_out,
    output logic [KEY_WIDTH-1:0]     take_key_out,
    output logic [PAYLOAD_WIDTH-1:0] take_payload_out
);
    import spq_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic [KEY_WIDTH-1:0]     key_reg;
    logic [KEY_WIDTH-1:0]     key_next;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_next;
    logic                     hit;
    logic                     first;

    // A cell hits when the operation's position could be here; the first hit in the
    // chain is the position itself.
    always_comb
    begin
        hit = 1'b0;
        priority if (ctl.ins)
        begin
            hit = !valid_reg
                || (ctl.order == ORDER_ASC && key_reg > new_key)
                || (ctl.order == ORDER_DESC && key_reg < new_key);
        end
        else if (ctl.deq)
        begin
            hit = valid_reg;
        end
        else if (ctl.rem)
        begin
            hit = valid_reg && key_reg == new_key;
        end
        else
        begin
            hit = 1'b0;
        end
    end

    assign first            = hit && !found_in;
    assign found_out        = found_in || hit;
    assign take_key_out     = first ? key_reg : take_key_in;
    assign take_payload_out = first ? payload_reg : take_payload_in;

    always_comb
    begin
        valid_next   = valid_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        priority if (ctl.ins && first)
        begin
            valid_next   = 1'b1;
            key_next     = new_key;
            payload_next = new_payload;
        end
        else if (ctl.ins && found_in)
        begin
            valid_next   = left_valid;
            key_next     = left_key;
            payload_next = left_payload;
        end
        else if ((ctl.deq || ctl.rem) && found_out)
        begin
            valid_next   = right_valid;
            key_next     = right_key;
            payload_next = right_payload;
        end
        else
        begin
            valid_next   = valid_reg;
            key_next     = key_reg;
            payload_next = payload_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign valid   = valid_reg;
    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

// File: rtl/spq_checker.sv
module spq_checker #(
    parameter int DEPTH         = 16,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 16,
    parameter int CNT_WIDTH     = $clog2(DEPTH + 1)
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [1:0]               status,
    input logic [KEY_WIDTH-1:0]     out_key,
    input logic [PAYLOAD_WIDTH-1:0] out_payload,
    input logic [CNT_WIDTH-1:0]     occupancy
);
    import spq_pkg::*;

    // A stalled result transaction must hold its status, key, payload and occupancy.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_key)
            && $stable(out_payload) && $stable(occupancy))
        else $error("stalled result changed");

    // An accepted transaction always produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted transaction produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= CNT_WIDTH'(DEPTH))
        else $error("occupancy beyond depth");

    // Failed operations report neither key nor payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_DONE |-> out_key == '0 && out_payload == '0)
        else $error("failed operation returned data");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FULL |-> occupancy == CNT_WIDTH'(DEPTH))
        else $error("full status with free entries");

endmodule

bind sorted_insert_priority_queue spq_checker #(
    .DEPTH        (DEPTH),
    .KEY_WIDTH    (KEY_WIDTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH),
    .CNT_WIDTH    (CNT_WIDTH)
) u_spq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_key    (out_key),
    .out_payload(out_payload),
    .occupancy  (occupancy)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int DEPTH = 16;
    localparam int KEY_W = 32;
    localparam int PAY_W = 16;
    localparam int CNT_W = 5;

    localparam logic [1:0] FUNC_NOP    = 2'd3;
    localparam logic [1:0] ORDER_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [CNT_W-1:0] count;
    } queue_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       queue_order;
    logic             in_valid;
    logic             in_stall;
    logic [1:0]       func;
    logic [KEY_W-1:0] item_key;
    logic [PAY_W-1:0] item_payload;
    logic             out_valid;
    logic             out_stall;
    logic [1:0]       status;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [CNT_W-1:0] occupancy;

    logic [KEY_W-1:0] model_keys [DEPTH];
    logic [PAY_W-1:0] model_pays [DEPTH];
    int               model_count = 0;
    logic [1:0]       model_order = ORDER_FIFO;

    queue_result_t    pending_results [$];
    int               mismatch_count = 0;
    int               ops_accepted = 0;
    int               results_checked = 0;
    int               full_seen = 0;
    int               miss_seen = 0;
    bit               idle_on = 1'b1;

    sorted_insert_priority_queue #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_W),
        .PAYLOAD_WIDTH (PAY_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .queue_order  (queue_order),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .item_key     (item_key),
        .item_payload (item_payload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_key      (out_key),
        .out_payload  (out_payload),
        .occupancy    (occupancy)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic queue_result_t apply_queue_op(input logic [1:0] op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [PAY_W-1:0] pay);
        queue_result_t r;
        int            pos;
        int            i;
        r = '0;
        pos = -1;
        case (op)
            FUNC_INSERT:
            begin
                if (model_count >= DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    pos = model_count;
                    for (i = model_count - 1; i >= 0; i--)
                    begin
                        if ((model_order == ORDER_ASC && model_keys[i] > key) ||
                            (model_order == ORDER_DESC && model_keys[i] < key))
                            pos = i;
                    end
                    for (i = model_count; i > pos; i--)
                    begin
                        model_keys[i] = model_keys[i-1];
                        model_pays[i] = model_pays[i-1];
                    end
                    model_keys[pos] = key;
                    model_pays[pos] = pay;
                    model_count++;
                end
            end
            FUNC_DEQUEUE:
            begin
                if (model_count > 0)
                    pos = 0;
            end
            FUNC_REMOVE:
            begin
                for (i = model_count - 1; i >= 0; i--)
                begin
                    if (model_keys[i] == key)
                        pos = i;
                end
            end
            default:
            begin
            end
        endcase
        if (op == FUNC_DEQUEUE || op == FUNC_REMOVE)
        begin
            if (pos < 0)
            begin
                r.status = STATUS_MISS;
            end
            else
            begin
                r.key = model_keys[pos];
                r.payload = model_pays[pos];
                for (i = pos; i + 1 < model_count; i++)
                begin
                    model_keys[i] = model_keys[i+1];
                    model_pays[i] = model_pays[i+1];
                end
                model_count--;
            end
        end
        r.count = CNT_W'(model_count);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : monitor
        queue_result_t want;
        queue_result_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{status, out_key, out_payload, occupancy};
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result arrived with no transaction outstanding");
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.key != want.key)
                        report_mismatch($sformatf("out_key %h, expected %h",
                                                  got.key, want.key));
                    if (got.payload != want.payload)
                        report_mismatch($sformatf("out_payload %h, expected %h",
                                                  got.payload, want.payload));
                    if (got.count != want.count)
                        report_mismatch($sformatf("occupancy %0d, expected %0d",
                                                  got.count, want.count));
                end
            end
            if (in_valid && !in_stall)
            begin
                want = apply_queue_op(func, item_key, item_payload);
                pending_results.push_back(want);
                ops_accepted++;
                if (want.status == STATUS_FULL)
                    full_seen++;
                if (want.status == STATUS_MISS)
                    miss_seen++;
            end
            if (cfg_valid && cfg_ready)
                model_order = queue_order;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid = 1'b1;
        func = op;
        item_key = key;
        item_payload = pay;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_order(input logic [1:0] order);
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        queue_order = order;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_fifo_basics();
        write_order(ORDER_FIFO);
        send_op(FUNC_DEQUEUE, '0, '0);
        send_op(FUNC_REMOVE, '0, '0);
        send_op(FUNC_NOP, '1, '1);
        send_op(FUNC_INSERT, '0, '0);
        send_op(FUNC_INSERT, '1, '1);
        send_op(FUNC_INSERT, 32'd5, 16'd1);
        send_op(FUNC_INSERT, 32'd5, 16'd2);
        send_op(FUNC_REMOVE, 32'd5, '0);
        send_op(FUNC_REMOVE, 32'd7, '0);
        send_op(FUNC_NOP, '0, '0);
        send_op(FUNC_DEQUEUE, '1, '1);
        send_op(FUNC_DEQUEUE, '0, '0);
        send_op(FUNC_DEQUEUE, '0, '0);
        send_op(FUNC_DEQUEUE, '0, '0);
    endtask

    task automatic test_sorted_orders();
        write_order(ORDER_ASC);
        send_op(FUNC_INSERT, 32'd3, 16'hA);
        send_op(FUNC_INSERT, 32'd1, 16'hB);
        send_op(FUNC_INSERT, 32'd3, 16'hC);
        send_op(FUNC_INSERT, '1, 16'hD);
        send_op(FUNC_INSERT, 32'd2, 16'hE);
        send_op(FUNC_REMOVE, 32'd3, '0);
        send_op(FUNC_DEQUEUE, '0, '0);
        send_op(FUNC_DEQUEUE, '0, '0);
        send_op(FUNC_REMOVE, '1, '0);
        send_op(FUNC_DEQUEUE, '0, '0);
        write_order(ORDER_DESC);
        send_op(FUNC_INSERT, 32'd1, 16'h1);
        send_op(FUNC_INSERT, 32'd3, 16'h2);
        send_op(FUNC_INSERT, 32'd3, 16'h3);
        send_op(FUNC_INSERT, '0, 16'h4);
        send_op(FUNC_INSERT, '1, 16'h5);
        send_op(FUNC_DEQUEUE, '0, '0);
        send_op(FUNC_REMOVE, 32'd3, '0);
        send_op(FUNC_REMOVE, 32'd1, '0);
        send_op(FUNC_DEQUEUE, '0, '0);
        send_op(FUNC_DEQUEUE, '0, '0);
    endtask

    task automatic test_full_and_empty();
        write_order(ORDER_SPARE);
        repeat (DEPTH + 1) send_op(FUNC_INSERT, $urandom, PAY_W'($urandom));
        repeat (DEPTH + 1) send_op(FUNC_DEQUEUE, '0, '0);
    endtask

    task automatic random_traffic(input int n, input int key_span);
        int               r;
        int               insert_pct;
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        repeat (n)
        begin
            insert_pct = model_count < 4 ? 75 : (model_count > 12 ? 35 : 55);
            r = $urandom_range(0, 99);
            if (r < 2)
                op = FUNC_NOP;
            else if (r < insert_pct)
                op = FUNC_INSERT;
            else if (r < insert_pct + (100 - insert_pct) / 2)
                op = FUNC_DEQUEUE;
            else
                op = FUNC_REMOVE;
            r = $urandom_range(0, 9);
            if (op == FUNC_REMOVE && model_count > 0 && r < 7)
                key = model_keys[$urandom_range(0, model_count - 1)];
            else if (r < 8)
                key = $urandom_range(0, key_span);
            else if (r < 9)
                key = $urandom;
            else
                key = $urandom_range(0, 1) ? '1 : '0;
            send_op(op, key, PAY_W'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        write_order(ORDER_ASC);
        random_traffic(100, 7);
        write_order(ORDER_DESC);
        random_traffic(100, 7);
        write_order(ORDER_FIFO);
        random_traffic(100, 1000);
        write_order(ORDER_SPARE);
        random_traffic(100, 7);
        write_order(ORDER_ASC);
        random_traffic(100, 1000);
        write_order(ORDER_DESC);
        random_traffic(100, 1000);
    endtask

    task automatic test_unstalled_tail();
        wait_drained();
        idle_on = 1'b0;
        write_order(ORDER_ASC);
        random_traffic(100, 15);
        write_order(ORDER_FIFO);
        random_traffic(100, 15);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        queue_order = ORDER_FIFO;
        in_valid = 1'b0;
        func = FUNC_INSERT;
        item_key = '0;
        item_payload = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fifo_basics();
        test_sorted_orders();
        test_full_and_empty();
        test_random_traffic();
        test_unstalled_tail();

        wait_drained();
        repeat (5) @(posedge clk);
        $display("Ran %0d transactions and checked %0d results in all four queue orders.",
                 ops_accepted, results_checked);
        $display("Inserts into a full queue: %0d, dequeues or removes that missed: %0d.",
                 full_seen, miss_seen);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
